// File: design/lsms_pkg.sv
package lsms_pkg;

  // item field widths
  localparam int ACTION_W = 2;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // stream word widths, padded to whole bytes
  localparam int IN_FIELDS_W  = ACTION_W + DATA_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STATUS_W + DATA_W + COUNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef logic [ACTION_W-1:0]      action_t;
  typedef logic [STATUS_W-1:0]      status_t;
  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [COUNT_W-1:0]       count_t;

  // action codes
  localparam action_t ACT_PUSH = 2'd0;
  localparam action_t ACT_POP  = 2'd1;
  localparam action_t ACT_PEEK = 2'd2;
  localparam action_t ACT_MIN  = 2'd3;

  // status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

endpackage

// File: design/lsms_mem.sv
// Single-port-write, single-port-read entry store; registered read data.
module lsms_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  lsms_pkg::word_t     wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output lsms_pkg::word_t     rdata
);

  lsms_pkg::word_t mem [DEPTH];
  lsms_pkg::word_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/lifo_stack_with_min_scan.sv
// Bounded LIFO stack of signed 32-bit words with a minimum query. Each input
// transfer carries one action (push, pop, peek, minimum) and yields exactly one
// result transfer with status, data and the entry count after the action.
// Entries live in a synchronous RAM with registered read data; the fill count
// is a register. Push and pop, and any action that fails on an empty or full
// stack, finish in the accept cycle. Peek issues the RAM read in the accept
// cycle, takes the read data in the scan state and loads the result in the
// finish state. Minimum walks every held entry through the single RAM read
// port, one entry per cycle. Only one action is in flight, so no RAM write and
// read ever overlap on the same entry. A one-deep output register holds the
// result; a new item is taken while the previous result leaves in that cycle.
// The count field is 7 bits and wraps when DEPTH exceeds 127.
module lifo_stack_with_min_scan #(
  parameter int DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: [1:0] action, [33:2] push_value, rest zero
  input  logic [lsms_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // out_tdata: [1:0] status, [33:2] data, [40:34] count, rest zero
  output logic [lsms_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [CW-1:0]         fill_r, fill_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;     // next entry to read
  logic                  first_r, first_nxt; // first read data of a scan
  lsms_pkg::word_t       best_r, best_nxt;

  logic                  out_valid_r, out_valid_nxt;
  lsms_pkg::status_t     out_status_r, out_status_nxt;
  lsms_pkg::word_t       out_data_r, out_data_nxt;
  lsms_pkg::count_t      out_count_r, out_count_nxt;

  lsms_pkg::action_t     in_action;
  lsms_pkg::word_t       in_push_value;
  logic                  accept;
  logic                  out_free;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  lsms_pkg::word_t       mem_rdata;

  logic                  is_empty, is_full;

  assign in_action     = in_tdata[lsms_pkg::ACTION_W-1:0];
  assign in_push_value = in_tdata[lsms_pkg::IN_FIELDS_W-1:lsms_pkg::ACTION_W];

  // result slot is free now or is emptied by the transfer in this cycle
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;

  assign is_empty = (fill_r == '0);
  assign is_full  = (fill_r == CW'(DEPTH));

  lsms_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_push_value),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    idx_nxt        = idx_r;
    first_nxt      = first_r;
    best_nxt       = best_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;
    mem_waddr      = fill_r[AW-1:0];
    mem_re         = 1'b0;
    mem_raddr      = idx_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_data_nxt = '0;
          unique case (in_action)
            lsms_pkg::ACT_PUSH: begin
              out_valid_nxt = 1'b1;
              if (is_full) begin
                out_status_nxt = lsms_pkg::ST_FULL;
              end else begin
                out_status_nxt = lsms_pkg::ST_OK;
                mem_we         = 1'b1;
                fill_nxt       = fill_r + 1'b1;
              end
              out_count_nxt = lsms_pkg::COUNT_W'(fill_nxt);
            end
            lsms_pkg::ACT_POP: begin
              out_valid_nxt = 1'b1;
              if (is_empty) begin
                out_status_nxt = lsms_pkg::ST_EMPTY;
              end else begin
                out_status_nxt = lsms_pkg::ST_OK;
                fill_nxt       = fill_r - 1'b1;
              end
              out_count_nxt = lsms_pkg::COUNT_W'(fill_nxt);
            end
            default: begin
              // peek is a one-entry scan starting at the top
              if (is_empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = lsms_pkg::ST_EMPTY;
                out_count_nxt  = lsms_pkg::COUNT_W'(fill_r);
              end else begin
                mem_re    = 1'b1;
                mem_raddr = (in_action == lsms_pkg::ACT_PEEK) ?
                            AW'(fill_r - 1'b1) : '0;
                idx_nxt   = (in_action == lsms_pkg::ACT_PEEK) ?
                            fill_r : CW'(1);
                first_nxt = 1'b1;
                state_nxt = S_SCAN;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        // mem_rdata holds the entry at idx_r - 1
        first_nxt = 1'b0;
        if (first_r || (mem_rdata < best_r)) begin
          best_nxt = mem_rdata;
        end
        if (idx_r == fill_r) begin
          state_nxt = S_FIN;
        end else begin
          mem_re  = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = lsms_pkg::ST_OK;
          out_data_nxt   = best_r;
          out_count_nxt  = lsms_pkg::COUNT_W'(fill_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    first_r      <= first_nxt;
    best_r       <= best_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = lsms_pkg::OUT_TDATA_W'({out_count_r, out_data_r, out_status_r});

endmodule
